>>> src/vcl_pkg.sv
package vcl_pkg;

  // Storage sizes
  localparam int VRAM_BYTES = 16384;
  localparam int VRAM_AW    = $clog2(VRAM_BYTES);
  localparam int PAL_BYTES  = 64;
  localparam int PAL_AW     = $clog2(PAL_BYTES);
  localparam int REG_COUNT  = 16;

  // Raster timing
  localparam logic [8:0] LAST_LINE    = 9'd261;
  localparam logic [8:0] ACTIVE_LINES = 9'd192;

  // Mode register slots and bits used here
  localparam logic [3:0] REG_IRQ_LINE   = 4'd0;
  localparam logic [3:0] REG_IRQ_FRAME  = 4'd1;
  localparam logic [3:0] REG_LINE_RELOAD = 4'd10;
  localparam int         BIT_LINE_EN    = 4;
  localparam int         BIT_FRAME_EN   = 5;

  localparam logic [7:0] REG_INIT [REG_COUNT] = '{
    8'h36, 8'ha0, 8'hff, 8'hff, 8'hff, 8'hff, 8'hfb, 8'h00,
    8'h00, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Bus operations
  typedef enum logic [2:0] {
    OP_DATA_RD   = 3'd0,
    OP_DATA_WR   = 3'd1,
    OP_STATUS_RD = 3'd2,
    OP_CTRL_WR   = 3'd3,
    OP_LINE_RD   = 3'd4,
    OP_TICK      = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] write_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       irq;
  } out_rsp_t;

endpackage

>>> src/video_chip_host_ports_line_irq.sv
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_ready   | in_req (opcode, write_byte)
// out_    | output    | out_valid / out_ready | out_rsp (read_byte, irq)
// cfg_    | input     | cfg_valid / cfg_ready | cfg_handheld_mode
//
// One request can be accepted every cycle while in_ready is high; its response passes
// one stage to catch the single-port RAM read data, then one output register.
// After reset a clearing pass zeroes VRAM and palette RAM; in_ready stays low
// during it, cfg writes are taken throughout. A stalled output holds the middle
// stage, and outside the clearing pass in_ready drops only then.
module video_chip_host_ports_line_irq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vcl_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output vcl_pkg::out_rsp_t out_rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_handheld_mode
);

  import vcl_pkg::*;

  // Architectural state
  logic                 hh_r;
  logic [14:0]          acc_addr_r, acc_addr_nxt;
  logic [7:0]           prefetch_r, prefetch_nxt;
  logic [7:0]           latch_r, latch_nxt;
  logic                 pend_r, pend_nxt;
  logic                 frame_r, frame_nxt;
  logic                 line_r, line_nxt;
  logic [8:0]           scan_r, scan_nxt;
  logic [7:0]           lcnt_r, lcnt_nxt;
  logic [7:0]           regs_r [REG_COUNT];
  logic                 pf_pend_r, pf_pend_nxt;

  // Clearing pass
  logic                 clr_r;
  logic [VRAM_AW-1:0]   clr_addr_r;

  // Pipeline
  logic                 s1_valid_r;
  logic                 s1_pal_r;
  logic [7:0]           s1_byte_r;
  logic                 s1_irq_r;
  logic                 out_valid_r;
  out_rsp_t             out_rsp_r;

  // Memory ports
  logic                 vram_we, vram_re;
  logic [VRAM_AW-1:0]   vram_addr;
  logic [7:0]           vram_wdata, vram_q;
  logic                 pal_we, pal_re;
  logic [PAL_AW-1:0]    pal_addr;
  logic [7:0]           pal_wdata, pal_q;

  // Request decode results
  logic                 accept, s1_move;
  logic                 reg_we;
  logic [7:0]           rd_byte;
  logic                 rd_pal;
  logic                 irq_nxt;
  logic [5:0]           pal_mask;
  logic [PAL_AW-1:0]    pal_idx;
  logic [14:0]          pal_next_addr, vram_next_addr;
  logic [7:0]           wb;

  assign s1_move   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !clr_r && (!s1_valid_r || s1_move);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;
  assign wb        = in_req.write_byte;

  // Palette addressing follows the handheld mode
  assign pal_mask       = {hh_r, 5'h1f};
  assign pal_idx        = acc_addr_r[5:0] & pal_mask;
  assign pal_next_addr  = {1'b1, 8'd0, (acc_addr_r[5:0] + 6'd1) & pal_mask};
  assign vram_next_addr = {1'b0, acc_addr_r[13:0] + 14'd1};

  vcl_ram #(.DEPTH(VRAM_BYTES), .WIDTH(8)) u_vram (
    .clk   (clk),
    .we    (vram_we),
    .re    (vram_re),
    .addr  (vram_addr),
    .wdata (vram_wdata),
    .rdata (vram_q)
  );

  vcl_ram #(.DEPTH(PAL_BYTES), .WIDTH(8)) u_pal (
    .clk   (clk),
    .we    (pal_we),
    .re    (pal_re),
    .addr  (pal_addr),
    .wdata (pal_wdata),
    .rdata (pal_q)
  );

  // Request execution: state update and memory access in the accept cycle; clearing-pass writes while clearing
  always_comb begin
    acc_addr_nxt = acc_addr_r;
    latch_nxt    = latch_r;
    pend_nxt     = pend_r;
    frame_nxt    = frame_r;
    line_nxt     = line_r;
    scan_nxt     = scan_r;
    lcnt_nxt     = lcnt_r;
    // a prefetch issued last cycle lands now
    prefetch_nxt = pf_pend_r ? vram_q : prefetch_r;
    pf_pend_nxt  = 1'b0;
    reg_we       = 1'b0;
    rd_byte      = 8'd0;
    rd_pal       = 1'b0;
    vram_we      = 1'b0;
    vram_re      = 1'b0;
    vram_addr    = acc_addr_r[13:0];
    vram_wdata   = wb;
    pal_we       = 1'b0;
    pal_re       = 1'b0;
    pal_addr     = pal_idx;
    pal_wdata    = wb;

    if (clr_r) begin
      vram_we    = 1'b1;
      vram_addr  = clr_addr_r;
      vram_wdata = 8'd0;
      pal_we     = 1'b1;
      pal_addr   = clr_addr_r[PAL_AW-1:0];
      pal_wdata  = 8'd0;
    end else if (accept) begin
      unique case (in_req.opcode)
        OP_DATA_RD: begin
          pend_nxt = 1'b0;
          if (acc_addr_r[14]) begin
            pal_re       = 1'b1;
            rd_pal       = 1'b1;
            acc_addr_nxt = pal_next_addr;
          end else begin
            rd_byte      = prefetch_nxt;
            vram_re      = 1'b1;
            pf_pend_nxt  = 1'b1;
            acc_addr_nxt = vram_next_addr;
          end
        end
        OP_DATA_WR: begin
          pend_nxt = 1'b0;
          if (acc_addr_r[14]) begin
            pal_we       = 1'b1;
            acc_addr_nxt = pal_next_addr;
          end else begin
            vram_we      = 1'b1;
            prefetch_nxt = wb;
            acc_addr_nxt = vram_next_addr;
          end
        end
        OP_STATUS_RD: begin
          rd_byte   = {frame_r, line_r, 6'd0};
          frame_nxt = 1'b0;
          line_nxt  = 1'b0;
          pend_nxt  = 1'b0;
        end
        OP_CTRL_WR: begin
          if (!pend_r) begin
            latch_nxt = wb;
            pend_nxt  = 1'b1;
          end else begin
            pend_nxt = 1'b0;
            if (wb[7]) begin
              if (wb[6]) begin
                acc_addr_nxt = {1'b1, 8'd0, latch_r[5:0] & pal_mask};
              end else begin
                reg_we = 1'b1;
              end
            end else if (wb[6]) begin
              acc_addr_nxt = {1'b0, wb[5:0], latch_r};
            end else begin
              // read setup: prefetch then step past it
              vram_re      = 1'b1;
              vram_addr    = {wb[5:0], latch_r};
              pf_pend_nxt  = 1'b1;
              acc_addr_nxt = {1'b0, vram_addr + 14'd1};
            end
          end
        end
        OP_LINE_RD: begin
          rd_byte = (scan_r < ACTIVE_LINES) ? scan_r[7:0] : 8'hff;
        end
        OP_TICK: begin
          if (scan_r == ACTIVE_LINES) begin
            frame_nxt = 1'b1;
          end
          if (scan_r == LAST_LINE) begin
            scan_nxt = 9'd0;
            lcnt_nxt = regs_r[REG_LINE_RELOAD];
          end else begin
            scan_nxt = scan_r + 9'd1;
            if (scan_nxt < ACTIVE_LINES) begin
              if (lcnt_r == 8'd0) begin
                line_nxt = 1'b1;
                lcnt_nxt = regs_r[REG_LINE_RELOAD];
              end else begin
                lcnt_nxt = lcnt_r - 8'd1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Interrupt level after the request, seeing a register write made by it
  always_comb begin
    logic en_frame;
    logic en_line;
    en_frame = (reg_we && wb[3:0] == REG_IRQ_FRAME) ? latch_r[BIT_FRAME_EN]
                                                    : regs_r[REG_IRQ_FRAME][BIT_FRAME_EN];
    en_line  = (reg_we && wb[3:0] == REG_IRQ_LINE) ? latch_r[BIT_LINE_EN]
                                                   : regs_r[REG_IRQ_LINE][BIT_LINE_EN];
    irq_nxt  = (frame_nxt && en_frame) || (line_nxt && en_line);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hh_r       <= 1'b0;
      acc_addr_r <= '0;
      prefetch_r <= '0;
      latch_r    <= '0;
      pend_r     <= 1'b0;
      frame_r    <= 1'b0;
      line_r     <= 1'b0;
      scan_r     <= '0;
      lcnt_r     <= '0;
      pf_pend_r  <= 1'b0;
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      for (int i = 0; i < REG_COUNT; i++) begin
        regs_r[i] <= REG_INIT[i];
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        hh_r <= cfg_handheld_mode;
      end
      acc_addr_r <= acc_addr_nxt;
      prefetch_r <= prefetch_nxt;
      latch_r    <= latch_nxt;
      pend_r     <= pend_nxt;
      frame_r    <= frame_nxt;
      line_r     <= line_nxt;
      scan_r     <= scan_nxt;
      lcnt_r     <= lcnt_nxt;
      pf_pend_r  <= pf_pend_nxt;
      if (reg_we) begin
        regs_r[wb[3:0]] <= latch_r;
      end
      // sweep VRAM once after reset; palette addresses wrap within the same pass
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (&clr_addr_r) begin
          clr_r <= 1'b0;
        end
      end
    end
  end

  // Read-data stage and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pal_r  <= rd_pal;
      s1_byte_r <= rd_byte;
      s1_irq_r  <= irq_nxt;
    end
    if (s1_move) begin
      out_rsp_r.read_byte <= s1_pal_r ? pal_q : s1_byte_r;
      out_rsp_r.irq       <= s1_irq_r;
    end
  end

`ifndef NO_ASSERTIONS
  // no request slips in while the RAMs are being cleared
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !in_ready)
    else $error("request accepted during clearing pass");

  // a pending prefetch always comes from a request accepted the cycle before
  a_prefetch_origin: assert property (@(posedge clk) disable iff (!rst_n)
    pf_pend_r |-> $past(in_valid && in_ready))
    else $error("prefetch pending without a request");

  // palette addresses keep the middle bits clear
  a_pal_addr_form: assert property (@(posedge clk) disable iff (!rst_n)
    acc_addr_r[14] |-> acc_addr_r[13:6] == 8'd0)
    else $error("malformed palette address");

  // a stalled middle stage keeps its response
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_move |=> s1_valid_r && $stable(s1_byte_r) && $stable(pal_q))
    else $error("middle stage lost a response");

  // scanline stays inside the frame
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r <= LAST_LINE)
    else $error("scanline out of range");
`endif

endmodule

>>> src/vcl_ram.sv
module vcl_ram #(
  parameter  int DEPTH = 64,
  parameter  int WIDTH = 8,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read data, held when not reading
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
